### hw/rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared types, command codes and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

   localparam int unsigned ResW = 31;
   localparam int unsigned ExpW = 63;
   localparam int unsigned RawW = 64;
   localparam logic [ResW-1:0] ModulusReset = 31'd1000000007;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0,
      CMD_SUB = 4'd1,
      CMD_MUL = 4'd2,
      CMD_DIV = 4'd3,
      CMD_POW = 4'd4,
      CMD_INV = 4'd5,
      CMD_NEG = 4'd6,
      CMD_RED = 4'd7,
      CMD_INC = 4'd8,
      CMD_DEC = 4'd9
   } cmd_type;

   typedef struct packed {
      logic [3:0]      cmd;
      logic [ResW-1:0] left;
      logic [ResW-1:0] right;
      logic [ExpW-1:0] exponent;
      logic [RawW-1:0] raw;
   } req_type;

   typedef struct packed {
      logic [ResW-1:0] value;
      logic            no_inverse;
      logic            bad_operand;
      logic            operands_equal;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RED_START,
      ST_RED_WAIT,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_POW_STEP,
      ST_POW_SQ_WAIT,
      ST_INV_START,
      ST_INV_WAIT,
      ST_DIV_MUL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      INV_IDLE,
      INV_CHECK,
      INV_DIVIDE,
      INV_UPDATE
   } inv_state_type;

endpackage

`default_nettype wire

### hw/rtl/modular_arithmetic_unit_top.sv
// Modular arithmetic unit, one request at a time. Add, sub, negate, increment, decrement
// and unused commands are computed in the decode state; multiply and reduce use the
// serial reducer, inverse runs Euclid steps in mau_inverse and divide adds a multiply
// after it; power walks up to 63 exponent bits, each a squaring plus a multiply when the
// bit is set. A new request is taken the cycle after the previous result is registered.
// Synchronous reset sets the modulus to 1000000007.
`default_nettype none

module modular_arithmetic_unit_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mau_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mau_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [30:0]      csr_data
);
   import mau_pkg::*;

   state_type       state_ff, state_in;
   logic [ResW-1:0] mod_ff;
   req_type         req_ff, req_in;
   logic [ResW-1:0] acc_ff, acc_in, sq_ff, sq_in, aux_ff, aux_in;
   logic [ExpW-1:0] exp_ff, exp_in;
   logic            phase_ff, phase_in;
   logic            neg_ff, neg_in;
   rsp_type         res_ff, res_in;
   rsp_type         out_ff, out_in;
   logic            outv_ff, outv_in;

   logic            red_start, red_done;
   logic [63:0]     red_dividend;
   logic [ResW-1:0] red_rem;
   logic            inv_start, inv_done, inv_found;
   logic [ResW-1:0] inv_operand, inv_result;

   logic            use_l, use_r, bad;
   logic [ResW:0]   sum;
   logic [63:0]     mul_a, mul_b;

   mau_modred u_red (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (red_dividend),
      .modulus   (mod_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   mau_inverse u_inv (
      .clock   (clock),
      .reset   (reset),
      .start   (inv_start),
      .operand (inv_operand),
      .modulus (mod_ff),
      .done    (inv_done),
      .found   (inv_found),
      .inverse (inv_result)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= ModulusReset;
      end else if (csr_valid) begin
         mod_ff <= csr_data;
      end
   end

   always_comb begin
      use_l = 1'b0;
      use_r = 1'b0;
      case (req_ff.cmd) inside
         [CMD_ADD:CMD_DIV]: begin
            use_l = 1'b1;
            use_r = 1'b1;
         end
         [CMD_POW:CMD_NEG], CMD_INC, CMD_DEC: use_l = 1'b1;
         default: ;
      endcase
      bad = (req_ff.cmd <= CMD_DEC) && ((mod_ff < ResW'(2))
            || (use_l && req_ff.left >= mod_ff) || (use_r && req_ff.right >= mod_ff));
   end

   // The reducer product: a 31 x 31 multiply feeding a registered 64-bit operand.
   assign mul_a = {33'd0, sq_ff};
   assign mul_b = {33'd0, aux_ff};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      aux_in       = aux_ff;
      exp_in       = exp_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      outv_in      = outv_ff;
      red_start    = 1'b0;
      red_dividend = 64'(mul_a * mul_b);
      inv_start    = 1'b0;
      inv_operand  = aux_ff;
      sum          = '0;
      if (outv_ff && rsp_ready) begin
         outv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_in                = '0;
            res_in.operands_equal = (req_ff.left == req_ff.right);
            res_in.bad_operand    = bad;
            state_in              = ST_DONE;
            if (!bad) begin
               case (req_ff.cmd)
                  CMD_ADD: begin
                     sum = {1'b0, req_ff.left} + {1'b0, req_ff.right};
                     if (sum >= {1'b0, mod_ff}) sum = sum - {1'b0, mod_ff};
                     res_in.value = sum[ResW-1:0];
                  end
                  CMD_SUB: begin
                     sum = {1'b0, req_ff.left} - {1'b0, req_ff.right};
                     if (sum[ResW]) sum = sum + {1'b0, mod_ff};
                     res_in.value = sum[ResW-1:0];
                  end
                  CMD_MUL: begin
                     sq_in    = req_ff.left;
                     aux_in   = req_ff.right;
                     state_in = ST_MUL_START;
                  end
                  CMD_DIV: begin
                     aux_in   = req_ff.right;
                     state_in = ST_INV_START;
                  end
                  CMD_INV: begin
                     aux_in   = req_ff.left;
                     state_in = ST_INV_START;
                  end
                  CMD_POW: begin
                     acc_in   = ResW'(1);
                     sq_in    = req_ff.left;
                     exp_in   = req_ff.exponent;
                     phase_in = 1'b0;
                     state_in = ST_POW_STEP;
                  end
                  CMD_NEG: begin
                     res_in.value = (req_ff.left == '0) ? '0 : mod_ff - req_ff.left;
                  end
                  CMD_RED: begin
                     state_in = ST_RED_START;
                  end
                  CMD_INC: begin
                     sum = {1'b0, req_ff.left} + (ResW+1)'(1);
                     if (sum >= {1'b0, mod_ff}) sum = '0;
                     res_in.value = sum[ResW-1:0];
                  end
                  CMD_DEC: begin
                     res_in.value = (req_ff.left == '0) ? mod_ff - ResW'(1)
                                    : req_ff.left - ResW'(1);
                  end
                  default: ;
               endcase
            end
         end
         ST_RED_START: begin
            neg_in       = req_ff.raw[63];
            red_dividend = req_ff.raw[63] ? (64'd0 - req_ff.raw) : req_ff.raw;
            red_start    = 1'b1;
            state_in     = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (red_done) begin
               res_in.value = (neg_ff && red_rem != '0) ? mod_ff - red_rem : red_rem;
               state_in     = ST_DONE;
            end
         end
         ST_MUL_START: begin
            red_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (red_done) begin
               res_in.value = red_rem;
               state_in     = ST_DONE;
            end
         end
         ST_POW_STEP: begin
            // phase 0: multiply acc by sq if the bit is set; phase 1: square.
            if (exp_ff == '0) begin
               res_in.value = (mod_ff == ResW'(1)) ? '0 : acc_ff;
               state_in     = ST_DONE;
            end else if (!phase_ff) begin
               if (exp_ff[0]) begin
                  aux_in    = acc_ff;
                  red_dividend = 64'(mul_a * {33'd0, acc_ff});
                  red_start = 1'b1;
                  state_in  = ST_POW_SQ_WAIT;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               red_dividend = 64'(mul_a * mul_a);
               red_start    = 1'b1;
               state_in     = ST_POW_SQ_WAIT;
            end
         end
         ST_POW_SQ_WAIT: begin
            if (red_done) begin
               if (!phase_ff) begin
                  acc_in   = red_rem;
                  phase_in = 1'b1;
               end else begin
                  sq_in    = red_rem;
                  exp_in   = exp_ff >> 1;
                  phase_in = 1'b0;
               end
               state_in = ST_POW_STEP;
            end
         end
         ST_INV_START: begin
            inv_start = 1'b1;
            state_in  = ST_INV_WAIT;
         end
         ST_INV_WAIT: begin
            if (inv_done) begin
               if (!inv_found) begin
                  res_in.no_inverse = 1'b1;
                  state_in          = ST_DONE;
               end else if (req_ff.cmd == CMD_INV) begin
                  res_in.value = inv_result;
                  state_in     = ST_DONE;
               end else begin
                  sq_in    = req_ff.left;
                  aux_in   = inv_result;
                  state_in = ST_DIV_MUL;
               end
            end
         end
         ST_DIV_MUL: begin
            red_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         ST_DONE: begin
            // The finished result moves to the output register once it is free.
            if (!outv_ff || rsp_ready) begin
               out_in   = res_ff;
               outv_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
      end
      req_ff   <= req_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      aux_ff   <= aux_in;
      exp_ff   <= exp_in;
      phase_ff <= phase_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

endmodule

`default_nettype wire

### hw/rtl/mau_modred.sv
// ----------------------------------------------------------------------------
// Bit-serial modular reducer
// Computes x mod m for a 64-bit x, one dividend bit per cycle by shift and
// conditional subtract. Also serves a*b mod m by feeding the product.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_modred (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [63:0]               dividend,
   input  wire logic [mau_pkg::ResW-1:0]  modulus,
   output logic                           done,
   output logic [mau_pkg::ResW-1:0]       remainder
);
   import mau_pkg::*;

   logic [63:0]     x_ff, x_in;
   logic [ResW:0]   r_ff, r_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [ResW+1:0] shifted;

   always_comb begin
      x_in    = x_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {r_ff, x_ff[63]};
      if (start) begin
         x_in    = dividend;
         r_in    = '0;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Remainder stays below m, so one subtract per bit suffices.
         if (shifted >= {2'b00, modulus}) begin
            shifted = shifted - {2'b00, modulus};
         end
         r_in   = shifted[ResW:0];
         x_in   = {x_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff[ResW-1:0];

endmodule

`default_nettype wire

### hw/rtl/mau_inverse.sv
// ----------------------------------------------------------------------------
// Modular inverse unit
// Extended Euclid: finds a^-1 mod m when gcd(a, m) is 1, for odd and even
// moduli alike. Each quotient is found one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_inverse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mau_pkg::ResW-1:0]  operand,
   input  wire logic [mau_pkg::ResW-1:0]  modulus,
   output logic                           done,
   output logic                           found,
   output logic [mau_pkg::ResW-1:0]       inverse
);
   import mau_pkg::*;

   // Invariants: s0*a = r0 (mod m), s1*a = r1 (mod m); s0, s1 stay below m.
   inv_state_type   state_ff, state_in;
   logic [ResW-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [ResW-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [ResW-1:0] dvd_ff, dvd_in, rem_ff, rem_in, prod_ff, prod_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            done_ff, done_in, found_ff, found_in;
   logic            qbit;
   logic [ResW:0]   trial, dbl, acc, diff;

   always_comb begin
      state_in = state_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      trial    = {rem_ff, dvd_ff[ResW-1]};
      qbit     = 1'b0;
      dbl      = {prod_ff, 1'b0};
      acc      = '0;
      diff     = '0;
      if (start) begin
         r0_in    = operand;
         r1_in    = modulus;
         s0_in    = ResW'(1);
         s1_in    = '0;
         found_in = 1'b0;
         state_in = INV_CHECK;
      end else begin
         case (state_ff)
            INV_CHECK: begin
               if (r1_ff == '0) begin
                  // r0 is the gcd; an inverse exists only when it is one.
                  done_in  = 1'b1;
                  found_in = (r0_ff == ResW'(1));
                  state_in = INV_IDLE;
               end else begin
                  dvd_in   = r0_ff;
                  rem_in   = '0;
                  prod_in  = '0;
                  cnt_in   = '0;
                  state_in = INV_DIVIDE;
               end
            end
            INV_DIVIDE: begin
               // Long division of r0 by r1, most significant bit first. The
               // product of quotient and s1 mod m is built alongside it.
               qbit = (trial >= {1'b0, r1_ff});
               if (qbit) trial = trial - {1'b0, r1_ff};
               rem_in = trial[ResW-1:0];
               if (dbl >= {1'b0, modulus}) dbl = dbl - {1'b0, modulus};
               acc = qbit ? (dbl + {1'b0, s1_ff}) : dbl;
               if (acc >= {1'b0, modulus}) acc = acc - {1'b0, modulus};
               prod_in = acc[ResW-1:0];
               dvd_in  = {dvd_ff[ResW-2:0], 1'b0};
               cnt_in  = cnt_ff + 5'd1;
               if (cnt_ff == 5'(ResW - 1)) state_in = INV_UPDATE;
            end
            INV_UPDATE: begin
               r0_in = r1_ff;
               r1_in = rem_ff;
               s0_in = s1_ff;
               diff  = {1'b0, s0_ff} - {1'b0, prod_ff};
               s1_in = diff[ResW] ? ResW'(diff + {1'b0, modulus}) : diff[ResW-1:0];
               state_in = INV_CHECK;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= INV_IDLE;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

   assign done    = done_ff;
   assign found   = found_ff;
   assign inverse = s0_ff;

endmodule

`default_nettype wire
